/* rtl/bst_pkg.sv */
// Package for the bounded set table: sizes, request codes, beat payloads,
// controller states and the command and status bundles between the two halves.
// Has no dependencies.
package bst_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef struct packed {
        t_req                      req_type;
        logic signed [DATA_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic               present;
        logic               changed;
        logic               full_res;
        logic [COUNT_W-1:0] count;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic search;
        logic decide;
        logic shift;
        logic shift_end;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic search_done;
        logic shift_done;
        logic found;
        t_req req;
        logic out_busy;
    } t_dp_stat;

endpackage

/* rtl/bst_ctrl.sv */
// Controller for the bounded set table: sequences search, decision,
// compaction and result hand-off. Depends on bst_pkg.
module bst_ctrl import bst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.search_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.req == REQ_DELETE && i_stat.found) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.shift_end = 1'b1;
                    n_state         = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

/* rtl/bst_dpath.sv */
// Datapath for the bounded set table: entry memory, count, search and
// compaction pointers, result flags and the output register. Depends on bst_pkg.
module bst_dpath import bst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_in_data,
    input  t_dp_cmd  i_cmd,
    input  logic     i_out_stall,
    output t_dp_stat o_stat,
    output logic     o_out_valid,
    output t_out     o_out_data
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_value;
    t_req              r_req;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [IDX_W-1:0]  r_pos;
    logic              r_cmp_vld;
    logic              r_found;
    logic              r_present;
    logic              r_changed;
    logic              r_full;
    logic              r_out_valid;
    t_out              r_out_data;

    logic              hit_now;
    logic              is_full;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign hit_now = r_cmp_vld && (r_rd_data == r_value);
    assign is_full = (r_count >= CNT_W'(CAPACITY));
    assign rd_en   = ((i_cmd.search && !hit_now) || i_cmd.shift) && (r_idx < r_count);
    assign rd_addr = r_idx[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmp_idx - IDX_W'(1);
        wr_data = r_rd_data;
        if (i_cmd.shift && r_cmp_vld) begin
            wr_en = 1'b1;
        end
        if (i_cmd.decide && r_req == REQ_INSERT && !r_found && !is_full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (i_cmd.decide) begin
                if (r_req == REQ_CLEAR) begin
                    r_count <= '0;
                end else if (r_req == REQ_INSERT && !r_found && !is_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.shift_end) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_value <= i_in_data.value;
            r_req   <= i_in_data.req_type;
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (rd_en) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_cmp_idx <= rd_addr;
        if (i_cmd.search && hit_now) begin
            r_found <= 1'b1;
            r_pos   <= r_cmp_idx;
        end
        if (i_cmd.decide) begin
            r_present <= r_found;
            r_changed <= 1'b0;
            r_full    <= 1'b0;
            r_idx     <= CNT_W'(r_pos) + CNT_W'(1);
            case (r_req)
                REQ_CLEAR: begin
                    r_changed <= (r_count != '0);
                end
                REQ_INSERT: begin
                    if (!r_found) begin
                        r_changed <= !is_full;
                        r_full    <= is_full;
                    end
                end
                REQ_DELETE: begin
                    r_changed <= r_found;
                end
                default: begin
                    r_changed <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_data.present  <= r_present;
            r_out_data.changed  <= r_changed;
            r_out_data.full_res <= r_full;
            r_out_data.count    <= COUNT_W'(r_count);
        end
    end

    assign o_stat.search_done = hit_now || (!r_cmp_vld && (r_idx >= r_count));
    assign o_stat.shift_done  = !rd_en && !r_cmp_vld;
    assign o_stat.found       = r_found;
    assign o_stat.req         = r_req;
    assign o_stat.out_busy    = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a waiting beat");
    a_shift_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_end |-> (r_found && r_count != '0 && r_req == REQ_DELETE))
        else $error("compaction ended without a found entry");
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && r_cmp_vld) |-> (CNT_W'(r_cmp_idx) < r_count))
        else $error("compaction read beyond the count");
`endif

endmodule

/* rtl/bounded_set_table.sv */
// Top level of the bounded set table: joins the controller and the datapath.
// Depends on bst_pkg, bst_ctrl and bst_dpath.
//
//   channel  direction  handshake                 payload
//   request  in         i_in_valid / o_in_stall   i_in_data  (t_in)
//   result   out        o_out_valid / i_out_stall o_out_data (t_out)
//
// One request at a time, one entry compared per cycle: the search ends at a match or
// at the end of the count, then the request is decided and its result loads; the next
// request is taken only once the result has loaded. A delete that finds its entry adds
// compaction before its result loads. Reset clears the count and the controller, not
// the entry memory. A stalled result waits in the output register while the next
// request is taken.
module bounded_set_table import bst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/bounded_set_table_tb.sv */
// Self-checking testbench for bounded_set_table: directed and random clear, insert,
// delete and lookup requests under random idling and result stalls, checked against
// an in-bench set model. Depends on bst_pkg and the bounded_set_table RTL.
module bounded_set_table_tb import bst_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
    localparam int POOL_N       = 24;
    localparam int PHASE_ITEMS  = 230;

    class set_scoreboard;
        logic [DATA_W-1:0] members[CAPACITY];
        int                n_members;
        t_out              pending[$];
        int unsigned       errors;
        int unsigned       n_checked;
        int unsigned       n_refused;

        function new();
            n_members = 0;
            errors    = 0;
            n_checked = 0;
            n_refused = 0;
        endfunction

        function void note_request(t_in req);
            t_out res;
            int   pos;
            int   i;
            res = '0;
            pos = -1;
            for (i = 0; i < n_members; i++) begin
                if (pos < 0 && members[i] == req.value) begin
                    pos = i;
                end
            end
            res.present = (pos >= 0);
            case (req.req_type)
                REQ_CLEAR: begin
                    res.changed = (n_members != 0);
                    n_members = 0;
                end
                REQ_INSERT: begin
                    if (pos < 0) begin
                        if (n_members < CAPACITY) begin
                            members[n_members] = req.value;
                            n_members++;
                            res.changed = 1'b1;
                        end else begin
                            res.full_res = 1'b1;
                        end
                    end
                end
                REQ_DELETE: begin
                    if (pos >= 0) begin
                        for (i = pos; i + 1 < n_members; i++) begin
                            members[i] = members[i + 1];
                        end
                        n_members--;
                        res.changed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.count = COUNT_W'(n_members);
            pending.push_back(res);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     n_checked, what, got, want);
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result beat, count", got.count, 0);
            end else begin
                want = pending.pop_front();
                if (got.present !== want.present) begin
                    report_mismatch("present", got.present, want.present);
                end
                if (got.changed !== want.changed) begin
                    report_mismatch("changed", got.changed, want.changed);
                end
                if (got.full_res !== want.full_res) begin
                    report_mismatch("full_res", got.full_res, want.full_res);
                end
                if (got.count !== want.count) begin
                    report_mismatch("count", got.count, want.count);
                end
                if (want.full_res) begin
                    n_refused++;
                end
            end
            n_checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    set_scoreboard     sb = new();
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       cycles = 0;
    int unsigned       n_by_type[4] = '{0, 0, 0, 0};
    logic [DATA_W-1:0] value_pool[POOL_N];

    bounded_set_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_request(input t_req kind, input logic [DATA_W-1:0] val);
        t_in beat;
        beat.req_type = kind;
        beat.value    = val;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(beat);
        n_by_type[kind]++;
    endtask

    task automatic fill_pool();
        int i;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0000_0000;
        for (i = 4; i < POOL_N; i++) begin
            value_pool[i] = $urandom;
        end
    endtask

    task automatic random_request();
        int                roll;
        t_req              kind;
        logic [DATA_W-1:0] val;
        roll = $urandom_range(99);
        if (roll < 1) begin
            kind = REQ_CLEAR;
        end else if (roll < 46) begin
            kind = REQ_INSERT;
        end else if (roll < 73) begin
            kind = REQ_DELETE;
        end else begin
            kind = REQ_LOOKUP;
        end
        if ($urandom_range(99) < 80) begin
            val = value_pool[$urandom_range(POOL_N - 1)];
        end else begin
            val = $urandom;
        end
        send_request(kind, val);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        fill_pool();
        for (n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
        end
    endtask

    initial begin
        int i;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_CLEAR, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'h1234_5678);
        send_request(REQ_DELETE, 32'h1234_5678);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFF);
        send_request(REQ_DELETE, 32'h0000_0000);
        for (i = 0; i < CAPACITY - 3; i++) begin
            send_request(REQ_INSERT, 32'(i) * 32'h0F0F_0F0F + 32'h5);
        end
        send_request(REQ_INSERT, 32'hDEAD_BEEF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_DELETE, 32'h8000_0000);
        send_request(REQ_CLEAR, 32'h7FFF_FFFF);

        run_phase(33, 80);
        run_phase(80, 33);
        run_phase(0, 0);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d clears, %0d inserts, %0d deletes and %0d lookups;",
                 n_by_type[REQ_CLEAR], n_by_type[REQ_INSERT],
                 n_by_type[REQ_DELETE], n_by_type[REQ_LOOKUP]);
        $display("%0d results compared, %0d inserts refused on a full table, %0d errors.",
                 sb.n_checked, sb.n_refused, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
